@@ hdl/a85_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the ASCII85 encoder with line wrapping.
// Holds character codes, opcodes, the base-85 reciprocal and the queue types.
// No dependencies.
package a85_pkg;

    // Input opcodes
    localparam logic [1:0] OP_DATA   = 2'd0;
    localparam logic [1:0] OP_FINISH = 2'd1;
    localparam logic [1:0] OP_START  = 2'd2;

    // Configuration register map
    localparam int          APB_AW         = 3;
    localparam logic        REG_LINE_LIMIT = 1'b0;
    localparam logic [7:0]  LIMIT_RESET    = 8'd75;

    // Character codes
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_Z     = 8'h7A;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] COL_MAX  = 8'd255;

    // v / 85 == (v * RECIP_85) >> RECIP_SHIFT for every 32-bit v
    localparam logic [31:0] RECIP_85    = 32'hC0C0C0C1;
    localparam int          RECIP_SHIFT = 38;
    localparam int          QUOT_W      = 64 - RECIP_SHIFT;

    // Command queue between the front and the back
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    localparam logic [2:0] NDIG_FULL = 3'd5;
    localparam logic [2:0] DIG_TOP   = 3'd4;

    typedef struct packed {
        logic [31:0] value;  // group, left aligned
        logic [2:0]  ndig;   // digits to emit, zero when there is no group
        logic        zero;   // full all-zero group, emitted as 'z'
        logic        term;   // append the terminator
        logic        start;  // clear the line column, no output
    } a85_cmd_t;

    typedef struct packed {
        logic [4:0][7:0] chars;  // digit characters, most significant in [0]
        logic [2:0]      ndig;
        logic            zero;
        logic            term;
        logic            start;
    } a85_job_t;

endpackage

@@ hdl/a85_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts input beats, packs data bytes into a 32-bit group and
// issues flush, finish and start commands to the queue. Depends on a85_pkg.
module a85_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_opcode,
    input  logic [7:0]        s_data_byte,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output a85_pkg::a85_cmd_t cmd
);
    import a85_pkg::*;

    logic [31:0] buf_reg;
    logic [2:0]  cnt_reg;
    logic [31:0] buf_next;
    logic [2:0]  cnt_next;
    logic [31:0] aligned;
    logic        take;

    assign s_ready = cmd_ready;
    assign take    = s_valid && s_ready;

    always_comb begin
        case (cnt_reg)
            3'd1:    aligned = {buf_reg[7:0], 24'd0};
            3'd2:    aligned = {buf_reg[15:0], 16'd0};
            3'd3:    aligned = {buf_reg[23:0], 8'd0};
            default: aligned = buf_reg;
        endcase
    end

    always_comb begin
        buf_next  = buf_reg;
        cnt_next  = cnt_reg;
        cmd_valid = 1'b0;
        cmd.value = buf_reg;
        cmd.ndig  = NDIG_FULL;
        cmd.zero  = (buf_reg == 32'd0) && (cnt_reg == 3'd4);
        cmd.term  = 1'b0;
        cmd.start = 1'b0;
        case (s_opcode)
            OP_DATA: begin
                if (cnt_reg == 3'd4) begin
                    cmd_valid = s_valid;
                    buf_next  = {24'd0, s_data_byte};
                    cnt_next  = 3'd1;
                end else begin
                    buf_next  = {buf_reg[23:0], s_data_byte};
                    cnt_next  = cnt_reg + 3'd1;
                end
            end
            OP_FINISH: begin
                cmd_valid = s_valid;
                cmd.value = aligned;
                cmd.ndig  = (cnt_reg == 3'd0) ? 3'd0 : cnt_reg + 3'd1;
                cmd.term  = 1'b1;
                buf_next  = 32'd0;
                cnt_next  = 3'd0;
            end
            OP_START: begin
                cmd_valid = s_valid;
                cmd.ndig  = 3'd0;
                cmd.zero  = 1'b0;
                cmd.start = 1'b1;
                buf_next  = 32'd0;
                cnt_next  = 3'd0;
            end
            default: begin
                cmd_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg <= 32'd0;
            cnt_reg <= 3'd0;
        end else if (take) begin
            buf_reg <= buf_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ hdl/a85_cmd_fifo.sv @@
`timescale 1ns / 1ps
// Short command queue decoupling the front end from the back end.
// Register-based, QDEPTH entries. Depends on a85_pkg.
module a85_cmd_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  a85_pkg::a85_cmd_t in_cmd,
    output logic              out_valid,
    input  logic              out_ready,
    output a85_pkg::a85_cmd_t out_cmd
);
    import a85_pkg::*;

    a85_cmd_t       mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW:0]   count_reg;
    logic           push;
    logic           pop;

    assign in_ready  = (count_reg != QDEPTH[QAW:0]);
    assign out_valid = (count_reg != '0);
    assign out_cmd   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ hdl/a85_conv.sv @@
`timescale 1ns / 1ps
// Base-85 converter: turns a queued group into five digit characters,
// one digit per cycle through a reciprocal multiplier. Depends on a85_pkg.
module a85_conv (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  a85_pkg::a85_cmd_t cmd,
    output logic              job_valid,
    input  logic              job_ready,
    output a85_pkg::a85_job_t job
);
    import a85_pkg::*;

    logic              busy_reg;
    logic              valid_reg;
    logic [2:0]        idx_reg;
    logic [31:0]       val_reg;
    logic [63:0]       prod_reg;
    a85_job_t          job_reg;
    logic [QUOT_W-1:0] quot;
    logic [31:0]       quot32;
    logic [31:0]       quot85;
    logic [31:0]       rem;
    logic [31:0]       mul_in;
    logic [63:0]       prod_next;
    logic              take;

    assign cmd_ready = !busy_reg && !valid_reg;
    assign take      = cmd_valid && cmd_ready;
    assign job_valid = valid_reg;
    assign job       = job_reg;

    // Quotient of the value in val_reg, remainder by shift and add
    assign quot      = prod_reg[63:RECIP_SHIFT];
    assign quot32    = {{(32 - QUOT_W){1'b0}}, quot};
    assign quot85    = (quot32 << 6) + (quot32 << 4) + (quot32 << 2) + quot32;
    assign rem       = val_reg - quot85;
    assign mul_in    = busy_reg ? quot32 : cmd.value;
    assign prod_next = {32'd0, mul_in} * {32'd0, RECIP_85};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            if (valid_reg && job_ready) begin
                valid_reg <= 1'b0;
            end
            if (take) begin
                if (cmd.ndig != 3'd0) begin
                    busy_reg <= 1'b1;
                end else begin
                    valid_reg <= 1'b1;
                end
            end else if (busy_reg && (idx_reg == 3'd0)) begin
                busy_reg  <= 1'b0;
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (take) begin
            job_reg.ndig  <= cmd.ndig;
            job_reg.zero  <= cmd.zero;
            job_reg.term  <= cmd.term;
            job_reg.start <= cmd.start;
            val_reg       <= cmd.value;
            idx_reg       <= DIG_TOP;
        end else if (busy_reg) begin
            job_reg.chars[idx_reg] <= {1'b0, rem[6:0]} + CH_BANG;
            val_reg                <= quot32;
            idx_reg                <= idx_reg - 3'd1;
        end
    end

endmodule

@@ hdl/a85_emit.sv @@
`timescale 1ns / 1ps
// Emitter: walks a converted job character by character, inserts line
// breaks, appends the terminator and drives the output register. Uses a85_pkg.
module a85_emit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [7:0]        line_limit,
    input  logic              job_valid,
    output logic              job_ready,
    input  a85_pkg::a85_job_t job,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_out_char,
    output logic              m_last
);
    import a85_pkg::*;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_GROUP = 2'd1;
    localparam logic [1:0] PH_TERM  = 2'd2;
    localparam logic [1:0] TERM_END = 2'd2;

    logic [1:0] phase_reg;
    a85_job_t   job_reg;
    logic [2:0] pos_reg;
    logic [1:0] tpos_reg;
    logic [7:0] col_reg;
    logic       nl_done_reg;
    logic       m_valid_reg;
    logic [7:0] m_char_reg;
    logic       m_last_reg;

    logic       out_free;
    logic [7:0] grp_char;
    logic       grp_last;
    logic       need_nl;
    logic [7:0] term_char;
    logic [7:0] col_next;
    logic       char_go;

    assign job_ready  = (phase_reg == PH_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_out_char = m_char_reg;
    assign m_last     = m_last_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign grp_char = job_reg.zero ? CH_Z : job_reg.chars[pos_reg];
    assign grp_last = job_reg.zero || (pos_reg == (job_reg.ndig - 3'd1));
    assign need_nl  = !nl_done_reg && (col_reg >= line_limit) && (grp_char != CH_PCT);
    assign col_next = (col_reg == COL_MAX) ? col_reg : col_reg + 8'd1;
    assign char_go  = out_free && ((phase_reg == PH_GROUP) || (phase_reg == PH_TERM));

    always_comb begin
        case (tpos_reg)
            2'd0:    term_char = CH_TILDE;
            2'd1:    term_char = CH_GT;
            default: term_char = CH_NL;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            m_valid_reg <= 1'b0;
            col_reg     <= 8'd0;
            nl_done_reg <= 1'b0;
        end else begin
            if (char_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (phase_reg)
                PH_IDLE: begin
                    if (job_valid) begin
                        job_reg     <= job;
                        pos_reg     <= 3'd0;
                        tpos_reg    <= 2'd0;
                        nl_done_reg <= 1'b0;
                        if (job.start) begin
                            col_reg <= 8'd0;
                        end else if (job.zero || (job.ndig != 3'd0)) begin
                            phase_reg <= PH_GROUP;
                        end else begin
                            phase_reg <= PH_TERM;
                        end
                    end
                end
                PH_GROUP: begin
                    if (out_free) begin
                        if (need_nl) begin
                            m_char_reg  <= CH_NL;
                            m_last_reg  <= 1'b0;
                            col_reg     <= 8'd0;
                            nl_done_reg <= 1'b1;
                        end else begin
                            m_char_reg  <= grp_char;
                            m_last_reg  <= grp_last && !job_reg.term;
                            col_reg     <= col_next;
                            nl_done_reg <= 1'b0;
                            if (grp_last) begin
                                phase_reg <= job_reg.term ? PH_TERM : PH_IDLE;
                            end else begin
                                pos_reg <= pos_reg + 3'd1;
                            end
                        end
                    end
                end
                PH_TERM: begin
                    if (out_free) begin
                        m_char_reg  <= term_char;
                        m_last_reg  <= (tpos_reg == TERM_END);
                        if (tpos_reg == TERM_END) begin
                            phase_reg <= PH_IDLE;
                        end else begin
                            tpos_reg <= tpos_reg + 2'd1;
                        end
                    end
                end
                default: begin
                    phase_reg <= PH_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hdl/ascii85_encoder_line_wrap.sv @@
`timescale 1ns / 1ps
// Top level of the ASCII85 encoder with line wrapping: front end, command
// queue, base-85 converter and emitter, plus the APB register. Uses a85_pkg.
//
// Usage. Each input beat (s_valid/s_ready) carries an opcode and a byte:
// data, finish or start. Output beats (m_valid/m_ready) carry one character
// each, and m_last marks the final character that an input beat causes.
// A data beat produces characters only when it finds a full group waiting;
// finish flushes any pending group, full or partial, and appends the terminator and a newline;
// start clears the group and the line column and produces nothing.
// The line limit is set through the APB port at address 0 and should be
// written only while the block is idle. pready is always high.
// A group flush waits for the converter to produce its five digits, one per
// cycle, while a bare finish skips the conversion. Input beats are taken one
// per cycle while the four-entry command queue has room. The converter holds
// each group until the emitter accepts it, and neither takes a new group
// before it is through with the last one. A receiver stall holds the output
// beat and halts the emitter and converter; once the queue fills s_ready
// drops. Synchronous reset clears the group, the column, the queue and the
// output, and restores the line limit to 75.
module ascii85_encoder_line_wrap (
    input  logic                       aclk,
    input  logic                       aresetn,
    // Input channel
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_opcode,
    input  logic [7:0]                 s_data_byte,
    // Output channel
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [7:0]                 m_out_char,
    output logic                       m_last,
    // Configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [a85_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import a85_pkg::*;

    logic [7:0] line_limit_reg;
    logic       reg_sel;

    logic       fq_valid;
    logic       fq_ready;
    a85_cmd_t   fq_cmd;
    logic       qc_valid;
    logic       qc_ready;
    a85_cmd_t   qc_cmd;
    logic       ce_valid;
    logic       ce_ready;
    a85_job_t   ce_job;

    // Register decode: bit 2 of the address selects the register slot, so
    // the only register sits at byte address 0 and the next slot reads zero.
    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_LINE_LIMIT);
    assign prdata  = reg_sel ? {24'd0, line_limit_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_limit_reg <= LIMIT_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            line_limit_reg <= pwdata[7:0];
        end
    end

    // Front end classifies beats and queues the group work.
    a85_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_data_byte (s_data_byte),
        .cmd_valid   (fq_valid),
        .cmd_ready   (fq_ready),
        .cmd         (fq_cmd)
    );

    a85_cmd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_cmd    (fq_cmd),
        .out_valid (qc_valid),
        .out_ready (qc_ready),
        .out_cmd   (qc_cmd)
    );

    // The converter works on the next group while the emitter drains the last.
    a85_conv u_conv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (qc_valid),
        .cmd_ready (qc_ready),
        .cmd       (qc_cmd),
        .job_valid (ce_valid),
        .job_ready (ce_ready),
        .job       (ce_job)
    );

    a85_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .line_limit (line_limit_reg),
        .job_valid  (ce_valid),
        .job_ready  (ce_ready),
        .job        (ce_job),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_char (m_out_char),
        .m_last     (m_last)
    );

endmodule

@@ dv/a85_wrap_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the ASCII85 line-wrap encoder: watches the input, output and
// APB ports, predicts every character from its own model and compares.
// Depends on a85_pkg for opcodes, character codes and the register map.
module a85_wrap_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [1:0]                 s_opcode,
    input  logic [7:0]                 s_data_byte,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic [7:0]                 m_out_char,
    input  logic                       m_last,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [a85_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    input  logic [31:0]                prdata,
    input  logic                       pready,
    output int                         n_errors,
    output int                         n_pending,
    output int                         n_beats,
    output int                         n_chars,
    output int                         n_wraps,
    output int                         n_zgroups
);
    import a85_pkg::*;

    localparam int BASE = 85;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } a85_char_t;

    a85_char_t   want_q[$];
    logic [7:0]  beat_chars[$];
    logic [31:0] grp;
    logic [2:0]  grp_n;
    logic [7:0]  col;
    logic [7:0]  lim;

    task automatic log_fail(input string what);
        n_errors++;
        if (n_errors <= 10) $display("[%0t] %s", $time, what);
    endtask

    // One group character, with a newline in front once the column is full, unless the character is '%'.
    task automatic put_wrapped(input logic [7:0] c);
        if (col >= lim && c != CH_PCT) begin
            beat_chars.push_back(CH_NL);
            col = '0;
            n_wraps++;
        end
        beat_chars.push_back(c);
        if (col != COL_MAX) col++;
    endtask

    task automatic flush_group();
        logic [31:0] v;
        logic [7:0]  dig[5];
        int          i;
        v = grp;
        for (i = 4; i >= 0; i--) begin
            dig[i] = 8'(CH_BANG + (v % BASE));
            v = v / BASE;
        end
        if (grp == '0 && grp_n == 3'd4) begin
            put_wrapped(CH_Z);
            n_zgroups++;
        end else begin
            for (i = 0; i <= grp_n; i++) put_wrapped(dig[i]);
        end
        grp = '0;
        grp_n = '0;
    endtask

    task automatic predict_beat(input logic [1:0] op, input logic [7:0] b);
        a85_char_t c;
        int        i;
        beat_chars.delete();
        case (op)
            OP_DATA: begin
                if (grp_n == 3'd4) flush_group();
                grp = {grp[23:0], b};
                grp_n++;
            end
            OP_FINISH: begin
                if (grp_n != 0) begin
                    grp = grp << (8 * (4 - grp_n));
                    flush_group();
                end
                beat_chars.push_back(CH_TILDE);
                beat_chars.push_back(CH_GT);
                beat_chars.push_back(CH_NL);
            end
            OP_START: begin
                grp = '0;
                grp_n = '0;
                col = '0;
            end
            default: ;
        endcase
        for (i = 0; i < beat_chars.size(); i++) begin
            c.ch = beat_chars[i];
            c.last = (i == beat_chars.size() - 1);
            want_q.push_back(c);
        end
    endtask

    always @(posedge aclk) begin : watch
        a85_char_t want;
        if (!aresetn) begin
            want_q.delete();
            grp = '0;
            grp_n = '0;
            col = '0;
            lim = LIMIT_RESET;
            n_errors = 0;
            n_beats = 0;
            n_chars = 0;
            n_wraps = 0;
            n_zgroups = 0;
        end else begin
            // Results are retired before the new beat is predicted; a beat
            // cannot produce a character at the edge on which it is taken.
            if (m_valid && m_ready) begin
                n_chars++;
                if (want_q.size() == 0) begin
                    log_fail($sformatf("unexpected character 0x%02h last=%0b",
                                       m_out_char, m_last));
                end else begin
                    want = want_q.pop_front();
                    if (want.ch !== m_out_char || want.last !== m_last)
                        log_fail($sformatf("char 0x%02h last=%0b, expected 0x%02h last=%0b",
                                           m_out_char, m_last, want.ch, want.last));
                end
            end
            if (s_valid && s_ready) begin
                n_beats++;
                predict_beat(s_opcode, s_data_byte);
            end
            if (psel && penable && pready && paddr[APB_AW-1:2] == REG_LINE_LIMIT) begin
                if (pwrite)
                    lim = pwdata[7:0];
                else if (prdata[7:0] !== lim)
                    log_fail($sformatf("line limit read back as %0d, expected %0d",
                                       prdata[7:0], lim));
            end
        end
        n_pending = want_q.size();
    end

endmodule

@@ dv/ascii85_encoder_line_wrap_test.sv @@
`timescale 1ns / 1ps
// Top of the testbench for the ASCII85 line-wrap encoder: clock, reset,
// stimulus, receiver stalls and the verdict. Depends on a85_pkg, the block
// and a85_wrap_checker, which does all prediction and comparison.
module ascii85_encoder_line_wrap_test;
    import a85_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 7;
    // The drain wait must outlast the path from a beat to its first character;
    // this leaves a comfortable margin for beats that produce nothing.
    localparam int DRAIN_CYCLES = 24;
    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_BEATS  = 6;
    localparam int HOLD_BEATS   = 5 * PHASE_BEATS;
    localparam int SAT_GROUPS   = 52;

    // The opcode that the block must ignore has no name in the package.
    localparam logic [1:0]        OP_IGNORED = 2'd3;
    localparam logic [APB_AW-1:0] LIMIT_ADDR = {REG_LINE_LIMIT, 2'b00};
    // A group whose five base-85 digits are all '%', which never wraps.
    localparam logic [31:0]       PCT_GROUP  = 32'h0C98_00B4;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_opcode = OP_DATA;
    logic [7:0]  s_data_byte = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_char;
    logic        m_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int n_errors, n_pending, n_beats, n_chars, n_wraps, n_zgroups;
    int cycles = 0;
    int burst_left = 0;
    int n_limits = 0;
    // The stimulus bumps hold_asks; the receiver answers each request with
    // one long stall and then bumps hold_done.
    int hold_asks = 0;
    int hold_done = 0;

    always #HALF_PERIOD aclk = ~aclk;

    ascii85_encoder_line_wrap uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_data_byte (s_data_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_char  (m_out_char),
        .m_last      (m_last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    a85_wrap_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_data_byte (s_data_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_char  (m_out_char),
        .m_last      (m_last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .n_errors    (n_errors),
        .n_pending   (n_pending),
        .n_beats     (n_beats),
        .n_chars     (n_chars),
        .n_wraps     (n_wraps),
        .n_zgroups   (n_zgroups)
    );

    // Watchdog. The bound is several times the slowest plausible correct run:
    // every beat at thirteen characters, each waiting on the receiver's
    // sparsest stall pattern, plus the long hold and the sender's gaps.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d characters outstanding",
                     cycles, n_pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver. It switches between stall patterns every so often, so that
    // stalls land on every phase of the block's output, with stretches of
    // permanent readiness in between. A long hold is served when asked for.
    initial begin : receiver
        int mode;
        int left;
        int tick;
        mode = 0;
        left = 0;
        tick = 0;
        forever begin
            @(negedge aclk);
            if (hold_asks != hold_done) begin
                m_ready = 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                hold_done++;
            end
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(40, 160);
            end
            left--;
            tick++;
            case (mode)
                0:       m_ready = 1'b1;
                1:       m_ready = 1'($urandom_range(0, 1));
                2:       m_ready = ($urandom_range(0, 3) == 0);
                default: m_ready = (tick % 3 != 0);
            endcase
        end
    end

    // Offers one beat and holds it, payload unchanged, until it is taken.
    // The sender works in bursts; between bursts valid drops for a few
    // cycles. Always entered and left at a falling edge.
    task automatic push(input logic [1:0] op, input logic [7:0] b);
        if (burst_left == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? 80 : $urandom_range(1, 12);
        end
        s_valid = 1'b1;
        s_opcode = op;
        s_data_byte = b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        burst_left--;
    endtask

    // Data bytes of a whole group, most significant first.
    task automatic push_group(input logic [31:0] g);
        int i;
        for (i = 3; i >= 0; i--) push(OP_DATA, g[8 * i +: 8]);
    endtask

    task automatic push_ctrl(input logic [1:0] op);
        push(op, 8'($urandom_range(0, 255)));
    endtask

    // Setup phase then access phase; the checker watches the transfer and
    // compares a read with its own copy of the register.
    task automatic apb_xfer(input logic wr, input logic [31:0] wdata);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = wr;
        paddr = LIMIT_ADDR;
        pwdata = wdata;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Waits until every predicted character has come out, then lets the
    // block finish any beat that produces nothing.
    task automatic drain();
        s_valid = 1'b0;
        while (n_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic set_limit(input logic [7:0] v);
        drain();
        apb_xfer(1'b1, {24'd0, v});
        apb_xfer(1'b0, '0);
        n_limits++;
    endtask

    // Group contents weighted towards the interesting encodings: all-zero
    // groups ('z'), runs of '%', all ones and small values full of '!'.
    function automatic logic [31:0] pick_group();
        case ($urandom_range(0, 19))
            0, 1, 2: pick_group = '0;
            3, 4:    pick_group = PCT_GROUP;
            5:       pick_group = '1;
            6, 7:    pick_group = $urandom() >> $urandom_range(1, 31);
            default: pick_group = $urandom();
        endcase
    endfunction

    // Mostly well-formed streams (start, bytes, finish) with random content;
    // the rest is noise: stray finishes and starts, orphan bytes and the
    // ignored opcode, which does not count towards the budget.
    task automatic random_traffic(input int budget);
        int          sent;
        int          len;
        int          i;
        logic [31:0] word;
        sent = 0;
        word = '0;
        while (sent < budget) begin
            if ($urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 3))
                    0: push_ctrl(OP_IGNORED);
                    1: begin push_ctrl(OP_FINISH); sent++; end
                    2: begin push_ctrl(OP_START); sent++; end
                    default: begin push(OP_DATA, 8'($urandom_range(0, 255))); sent++; end
                endcase
            end else begin
                // Now and then the stream carries on the current line.
                if ($urandom_range(0, 4) != 0) begin
                    push_ctrl(OP_START);
                    sent++;
                end
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
                                                  : $urandom_range(4, 16);
                for (i = 0; i < len; i++) begin
                    if (i % 4 == 0) word = pick_group();
                    push(OP_DATA, word[31 - 8 * (i % 4) -: 8]);
                    sent++;
                end
                push_ctrl(OP_FINISH);
                sent++;
            end
        end
    endtask

    initial begin : stimulus
        int ph;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed beats at the reset line limit. First a finish with no
        // group, which gives only the terminator.
        push_ctrl(OP_FINISH);
        // Partial groups of one, two and three bytes; the two zero bytes
        // must not collapse to 'z'.
        push(OP_DATA, 8'hFF);
        push_ctrl(OP_FINISH);
        push(OP_DATA, 8'h00);
        push(OP_DATA, 8'h00);
        push_ctrl(OP_FINISH);
        push(OP_DATA, 8'h12);
        push(OP_DATA, 8'h34);
        push(OP_DATA, 8'h56);
        push_ctrl(OP_FINISH);
        // A full zero group flushed by finish still becomes 'z'.
        push_group('0);
        push_ctrl(OP_FINISH);
        // A full group flushed by the next data byte, then the ignored
        // opcode in the middle of a group.
        push_group('1);
        push(OP_DATA, 8'h80);
        push_ctrl(OP_IGNORED);
        push_ctrl(OP_FINISH);
        // Start discards a partial group.
        push(OP_DATA, 8'h41);
        push_ctrl(OP_START);
        push(OP_DATA, 8'h7F);
        push_ctrl(OP_FINISH);

        // Line limit of zero: every group character except '%' gets a
        // newline in front.
        set_limit(8'd0);
        push_ctrl(OP_START);
        push_group(PCT_GROUP);
        push_group($urandom());
        push_ctrl(OP_FINISH);

        // Column saturation: an unbroken run of '%' digits carries the column
        // past the largest limit up to its ceiling, and a normal group must
        // then wrap.
        set_limit(8'd240);
        push_ctrl(OP_START);
        repeat (SAT_GROUPS) push_group(PCT_GROUP);
        push_group($urandom());
        push_ctrl(OP_FINISH);

        // Random phases, each at its own line limit, taking in both ends of
        // the range and the reset value. In the third phase, which carries
        // the most beats, the receiver holds off for a long stretch while
        // beats keep coming, so the command queue fills and the input stalls.
        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0:       set_limit(8'd1);
                1:       set_limit(8'd240);
                3:       set_limit(LIMIT_RESET);
                default: set_limit(8'($urandom_range(2, 239)));
            endcase
            if (ph == 2) hold_asks++;
            random_traffic((ph == 2) ? HOLD_BEATS : PHASE_BEATS);
        end

        drain();
        $display("Run covered %0d input beats and %0d output characters, with %0d wraps",
                 n_beats, n_chars, n_wraps);
        $display("and %0d zero groups over %0d line-limit settings.", n_zgroups, n_limits);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches in total", n_errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/a85_pkg.sv
hdl/a85_front.sv
hdl/a85_cmd_fifo.sv
hdl/a85_conv.sv
hdl/a85_emit.sv
hdl/ascii85_encoder_line_wrap.sv
dv/a85_wrap_checker.sv
dv/ascii85_encoder_line_wrap_test.sv
